>>> rtl/core/pbb_pkg.sv
// Package for the pixel block binning unit: field widths, register indexes,
// limits, the result and geometry-status types and the saturating adder.
// No dependencies.
package pbb_pkg;

  localparam int PIX_W     = 16;
  localparam int FRAME_W   = 13;
  localparam int BIN_W     = 7;
  localparam int COORD_W   = 12;
  localparam int SUM_W     = 17;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_COLS = 4096;
  localparam int MAX_ROWS     = 4096;
  localparam int MAX_BIN      = 64;
  localparam int BIN_CNT_W    = $clog2(MAX_BIN);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_BIN    = 2'd3;

  localparam logic [FRAME_W-1:0] RST_FRAME_ROWS = 13'd4096;
  localparam logic [FRAME_W-1:0] RST_FRAME_COLS = 13'd4096;
  localparam logic [BIN_W-1:0]   RST_ROW_BIN    = 7'd2;
  localparam logic [BIN_W-1:0]   RST_COL_BIN    = 7'd2;

  // A sum of SUM_CAP stands for "more than the largest pixel value".
  localparam logic [SUM_W-1:0] SUM_CAP = 17'h10000;
  localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;

  typedef struct packed {
    logic busy;
    logic ok;
  } pbb_geom_t;

  typedef struct packed {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               clipped;
    logic               frame_end;
  } pbb_result_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SUM_CAP}) ? SUM_CAP : s[SUM_W-1:0];
  endfunction

endpackage

>>> rtl/core/pbb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module pbb_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pbb_geom.sv
// Geometry check: bin and size limits plus two bit-serial divisibility tests
// (frame size modulo bin), one dividend bit per cycle. Depends on pbb_pkg.
module pbb_geom import pbb_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [FRAME_W-1:0] frame_rows,
  input  logic [FRAME_W-1:0] frame_cols,
  input  logic [BIN_W-1:0]   row_bin,
  input  logic [BIN_W-1:0]   col_bin,
  output pbb_geom_t          geo
);

  localparam int STEP_W = $clog2(FRAME_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAME_W - 1);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] bit_idx;
  logic [BIN_W-1:0]  rem_r;
  logic [BIN_W-1:0]  rem_c;
  logic [BIN_W:0]    shift_r;
  logic [BIN_W:0]    shift_c;
  logic [BIN_W:0]    rem_r_next;
  logic [BIN_W:0]    rem_c_next;
  logic              limits_ok;
  logic              busy;
  logic              ok;

  assign bit_idx = LAST_STEP - step;
  assign shift_r = {rem_r, frame_rows[bit_idx]};
  assign shift_c = {rem_c, frame_cols[bit_idx]};

  // Restoring remainder step; the partial remainder stays below the bin.
  assign rem_r_next = (shift_r >= {1'b0, row_bin}) ? shift_r - {1'b0, row_bin} : shift_r;
  assign rem_c_next = (shift_c >= {1'b0, col_bin}) ? shift_c - {1'b0, col_bin} : shift_c;

  assign limits_ok = (row_bin != '0) && (col_bin != '0)
                  && (32'(row_bin) <= MAX_BIN) && (32'(col_bin) <= MAX_BIN)
                  && (32'(frame_cols) <= MAX_COLS) && (32'(frame_rows) <= MAX_ROWS)
                  && (frame_rows > FRAME_W'(row_bin)) && (frame_cols > FRAME_W'(col_bin));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy  <= 1'b1;
      step  <= '0;
      rem_r <= '0;
      rem_c <= '0;
      ok    <= 1'b0;
    end else if (busy) begin
      rem_r <= rem_r_next[BIN_W-1:0];
      rem_c <= rem_c_next[BIN_W-1:0];
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        ok   <= limits_ok && (rem_r_next == '0) && (rem_c_next == '0);
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  assign geo.busy = busy;
  assign geo.ok   = ok;

endmodule

>>> rtl/core/pbb_outq.sv
// Small register queue that holds finished binned pixels until the
// downstream side takes them. Depends on pbb_pkg.
module pbb_outq import pbb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pbb_result_t         push_data,
  input  logic                pop_stall,
  output logic                head_valid,
  output pbb_result_t         head_data,
  output logic [OQ_CNT_W-1:0] count
);

  pbb_result_t         entries [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic                pop;

  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign pop        = head_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

endmodule

>>> rtl/core/pixel_block_binning_unit.sv
// Top level of the pixel block binning unit: configuration registers, raster
// counters, the column-sum line store pipeline and the output queue.
// Depends on pbb_pkg, pbb_ram, pbb_geom and pbb_outq.
//
// The unit takes one pixel per clock in raster order while pix_stall is low
// and sums each block of row_bin rows by col_bin columns into one saturated
// 16-bit binned pixel. A pixel that closes a block is registered in stage s1,
// which then pushes its binned pixel into the output queue for downstream.
// Partial block sums live in a line store of MAX_COLS entries of 17 bits
// that is read when a block's column run ends and written back on the next
// cycle. After reset and after every register write the unit checks the
// geometry, one bit of each divisibility test per cycle, and holds pix_stall
// high meanwhile. Otherwise pix_stall rises only when the four-entry output
// queue is close to full. With a bad geometry, pixels are consumed and no
// binned pixel is produced.
module pixel_block_binning_unit import pbb_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [PIX_W-1:0]     pixel_value,
  output logic                 bin_valid,
  input  logic                 bin_stall,
  output logic [PIX_W-1:0]     binned_value,
  output logic [COORD_W-1:0]   out_row,
  output logic [COORD_W-1:0]   out_col,
  output logic                 clipped,
  output logic                 frame_end
);

  localparam int AW = $clog2(MAX_COLS);

  logic [FRAME_W-1:0] frame_rows;
  logic [FRAME_W-1:0] frame_cols;
  logic [BIN_W-1:0]   row_bin;
  logic [BIN_W-1:0]   col_bin;

  logic [SUM_W-1:0]     run_sum;
  logic [FRAME_W-1:0]   row_pos;
  logic [FRAME_W-1:0]   col_pos;
  logic [BIN_CNT_W-1:0] row_in_block;
  logic [BIN_CNT_W-1:0] col_in_block;
  logic [AW-1:0]        out_column;
  logic [COORD_W-1:0]   out_line;

  logic               s1_valid;
  logic               s1_first;
  logic               s1_emit;
  logic               s1_fend;
  logic [SUM_W-1:0]   s1_rs;
  logic [AW-1:0]      s1_addr;
  logic [COORD_W-1:0] s1_line;

  pbb_geom_t           geo;
  pbb_result_t         res;
  pbb_result_t         head;
  logic [OQ_CNT_W-1:0] q_count;
  logic                s1_push;

  logic               accept;
  logic               work;
  logic [SUM_W-1:0]   rs_sum;
  logic               blk_col_end;
  logic               blk_row_last;
  logic               line_end;
  logic               frame_last;
  logic               mem_re;
  logic [SUM_W-1:0]   mem_rdata;
  logic [SUM_W-1:0]   total;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= RST_FRAME_ROWS;
      frame_cols <= RST_FRAME_COLS;
      row_bin    <= RST_ROW_BIN;
      col_bin    <= RST_COL_BIN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_ROWS: frame_rows <= cfg_data[FRAME_W-1:0];
        REG_FRAME_COLS: frame_cols <= cfg_data[FRAME_W-1:0];
        REG_ROW_BIN:    row_bin    <= cfg_data[BIN_W-1:0];
        REG_COL_BIN:    col_bin    <= cfg_data[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  pbb_geom #(.MAX_COLS(MAX_COLS)) u_geom (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_write),
    .frame_rows (frame_rows),
    .frame_cols (frame_cols),
    .row_bin    (row_bin),
    .col_bin    (col_bin),
    .geo        (geo)
  );

  // A pixel taken now may push one more entry once it has passed stage s1, so
  // leave room for it on top of whatever is queued or about to be queued.
  assign s1_push   = s1_valid && s1_emit;
  assign pix_stall = geo.busy || ((32'(q_count) + 32'(s1_push)) >= OQ_DEPTH);
  assign accept    = pix_valid && !pix_stall;
  assign work      = accept && geo.ok;

  assign rs_sum       = sat_add(run_sum, SUM_W'(pixel_value));
  assign blk_col_end  = (BIN_W'(col_in_block) + BIN_W'(1)) == col_bin;
  assign blk_row_last = (BIN_W'(row_in_block) + BIN_W'(1)) == row_bin;
  assign line_end     = (col_pos + FRAME_W'(1)) == frame_cols;
  assign frame_last   = line_end && ((row_pos + FRAME_W'(1)) == frame_rows);

  // Raster counters and the running sum of the current block row segment.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      run_sum      <= '0;
      row_pos      <= '0;
      col_pos      <= '0;
      row_in_block <= '0;
      col_in_block <= '0;
      out_column   <= '0;
      out_line     <= '0;
    end else if (work) begin
      if (line_end) begin
        col_pos      <= '0;
        col_in_block <= '0;
        out_column   <= '0;
        run_sum      <= '0;
        if (frame_last) begin
          row_pos      <= '0;
          row_in_block <= '0;
          out_line     <= '0;
        end else begin
          row_pos <= row_pos + FRAME_W'(1);
          if (blk_row_last) begin
            row_in_block <= '0;
            out_line     <= out_line + COORD_W'(1);
          end else begin
            row_in_block <= row_in_block + BIN_CNT_W'(1);
          end
        end
      end else begin
        col_pos <= col_pos + FRAME_W'(1);
        if (blk_col_end) begin
          col_in_block <= '0;
          out_column   <= out_column + AW'(1);
          run_sum      <= '0;
        end else begin
          col_in_block <= col_in_block + BIN_CNT_W'(1);
          run_sum      <= rs_sum;
        end
      end
    end
  end

  // An entry is written back on the cycle after its read, and the same column
  // comes round again at least two pixels later, so no forwarding is needed.
  assign mem_re = work && blk_col_end && (row_in_block != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= work && blk_col_end;
    end
  end

  always_ff @(posedge clk) begin
    if (work && blk_col_end) begin
      s1_first <= (row_in_block == '0);
      s1_emit  <= blk_row_last;
      s1_fend  <= frame_last;
      s1_rs    <= rs_sum;
      s1_addr  <= out_column;
      s1_line  <= out_line;
    end
  end

  pbb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLS)) u_line_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (total),
    .re    (mem_re),
    .raddr (out_column),
    .rdata (mem_rdata)
  );

  assign total = s1_first ? s1_rs : sat_add(mem_rdata, s1_rs);

  assign res.value     = total[SUM_W-1] ? PIX_MAX : total[PIX_W-1:0];
  assign res.row       = s1_line;
  assign res.col       = COORD_W'(s1_addr);
  assign res.clipped   = total[SUM_W-1];
  assign res.frame_end = s1_fend;

  pbb_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_push),
    .push_data  (res),
    .pop_stall  (bin_stall),
    .head_valid (bin_valid),
    .head_data  (head),
    .count      (q_count)
  );

  assign binned_value = head.value;
  assign out_row      = head.row;
  assign out_col      = head.col;
  assign clipped      = head.clipped;
  assign frame_end    = head.frame_end;

endmodule

>>> rtl/core/pbb_checker.sv
// Port-level checks for the pixel block binning unit, bound to the top level.
// Depends on pbb_pkg and pixel_block_binning_unit.
module pbb_checker import pbb_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_write,
  input logic                 pix_stall,
  input logic                 bin_valid,
  input logic                 bin_stall,
  input logic [PIX_W-1:0]     binned_value,
  input logic [COORD_W-1:0]   out_row,
  input logic [COORD_W-1:0]   out_col,
  input logic                 clipped,
  input logic                 frame_end
);

  // The geometry check runs after reset, so no pixel is taken right away.
  a_stall_after_reset: assert property (@(posedge clk) rst |=> pix_stall)
    else $error("pixel taken right after reset");

  // A register write restarts the geometry check.
  a_stall_after_cfg: assert property (@(posedge clk) cfg_write |=> pix_stall)
    else $error("pixel taken right after a register write");

  a_no_out_after_reset: assert property (@(posedge clk) rst |=> !bin_valid)
    else $error("binned pixel present after reset");

  // A clipped beat always carries the saturated value.
  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    bin_valid && clipped |-> binned_value == PIX_MAX)
    else $error("clipped beat without saturated value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    bin_valid && bin_stall |=> bin_valid && $stable(binned_value)
      && $stable(out_row) && $stable(out_col) && $stable(frame_end))
    else $error("stalled output beat changed");

endmodule

bind pixel_block_binning_unit pbb_checker u_pbb_checker (.*);
